// ----- rtl/tosp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosp_pkg
// Codes, types and constants shared by the telnet option stream parser.
// ----------------------------------------------------------------------------
package tosp_pkg;

    // Telnet command and option bytes
    localparam logic [7:0] CMD_IAC      = 8'd255;
    localparam logic [7:0] CMD_SE       = 8'd240;
    localparam logic [7:0] CMD_SB       = 8'd250;
    localparam logic [7:0] CMD_WILL     = 8'd251;
    localparam logic [7:0] CMD_WONT     = 8'd252;
    localparam logic [7:0] CMD_DO       = 8'd253;
    localparam logic [7:0] CMD_DONT     = 8'd254;
    localparam logic [7:0] CMD_EOR      = 8'hef;
    localparam logic [7:0] OPT_BINARY   = 8'h00;
    localparam logic [7:0] OPT_TERMTYPE = 8'h18;
    localparam logic [7:0] OPT_EOR      = 8'h19;

    // Parse phases
    localparam logic [2:0] PH_NORMAL  = 3'd0;
    localparam logic [2:0] PH_IAC     = 3'd1;
    localparam logic [2:0] PH_OPTION  = 3'd2;
    localparam logic [2:0] PH_SUBTYPE = 3'd3;
    localparam logic [2:0] PH_SUBOP   = 3'd4;

    // Option verbs
    localparam logic [1:0] VERB_NONE  = 2'd0;
    localparam logic [1:0] VERB_WILL  = 2'd1;
    localparam logic [1:0] VERB_DO    = 2'd2;
    localparam logic [1:0] VERB_OTHER = 2'd3;

    // Result kinds
    localparam logic [2:0] K_NONE   = 3'd0;
    localparam logic [2:0] K_FWD    = 3'd1;
    localparam logic [2:0] K_DROP   = 3'd2;
    localparam logic [2:0] K_TTBYTE = 3'd3;
    localparam logic [2:0] K_TTEND  = 3'd4;
    localparam logic [2:0] K_EOR    = 3'd5;
    localparam logic [2:0] K_TTREQ  = 3'd6;

    typedef struct packed {
        logic [2:0] parse_phase;
        logic [1:0] option_verb;
        logic       in_subnegotiation;
        logic       will_binary_seen;
        logic       do_binary_seen;
        logic       will_record_end_seen;
        logic       do_record_end_seen;
        logic       terminal_type_seen;
    } tosp_state_t;

    typedef struct packed {
        logic [2:0] out_kind;
        logic [7:0] out_byte;
        logic       negotiation_done;
    } tosp_result_t;

endpackage

// ----- rtl/tosp_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosp_in_if
// Request channel carrying one received telnet byte.
// ----------------------------------------------------------------------------
interface tosp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/tosp_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosp_out_if
// Result channel carrying the kind, byte and negotiation status.
// ----------------------------------------------------------------------------
interface tosp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] out_kind;
    logic [7:0] out_byte;
    logic       negotiation_done;

    modport source (output valid, output out_kind, output out_byte,
                    output negotiation_done, input ready);
    modport sink   (input valid, input out_kind, input out_byte,
                    input negotiation_done, output ready);
endinterface

// ----- rtl/tosp_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosp_decode
// Next parser state and result for one byte, given the current state.
// ----------------------------------------------------------------------------
module tosp_decode
    import tosp_pkg::*;
(
    input  tosp_state_t  cur,
    input  logic [7:0]   rx_byte,
    output tosp_state_t  nxt,
    output tosp_result_t res
);

    logic       all_now;
    logic [2:0] data_kind;

    assign all_now = cur.will_binary_seen & cur.do_binary_seen &
                     cur.will_record_end_seen & cur.do_record_end_seen &
                     cur.terminal_type_seen;

    always_comb
    begin
        if (cur.in_subnegotiation)
            data_kind = K_TTBYTE;
        else if (all_now)
            data_kind = K_FWD;
        else
            data_kind = K_DROP;
    end

    always_comb
    begin
        nxt             = cur;
        nxt.parse_phase = PH_NORMAL;
        res.out_kind    = K_NONE;
        res.out_byte    = 8'd0;

        case (cur.parse_phase)
            PH_IAC:
            begin
                if (rx_byte == CMD_EOR)
                begin
                    res.out_kind = K_EOR;
                end
                else if (rx_byte == CMD_IAC)
                begin
                    // escaped 255 is an ordinary data byte
                    res.out_kind = data_kind;
                    res.out_byte = CMD_IAC;
                end
                else if (rx_byte == CMD_WILL || rx_byte == CMD_DO ||
                         rx_byte == CMD_WONT || rx_byte == CMD_DONT)
                begin
                    if (rx_byte == CMD_WILL)
                        nxt.option_verb = VERB_WILL;
                    else if (rx_byte == CMD_DO)
                        nxt.option_verb = VERB_DO;
                    else
                        nxt.option_verb = VERB_OTHER;
                    nxt.parse_phase = PH_OPTION;
                end
                else if (rx_byte == CMD_SB)
                begin
                    nxt.parse_phase = PH_SUBTYPE;
                end
                else if (rx_byte == CMD_SE && cur.in_subnegotiation)
                begin
                    nxt.in_subnegotiation  = 1'b0;
                    nxt.terminal_type_seen = 1'b1;
                    res.out_kind           = K_TTEND;
                end
            end
            PH_SUBTYPE:
            begin
                nxt.parse_phase = PH_SUBOP;
            end
            PH_SUBOP:
            begin
                nxt.in_subnegotiation = 1'b1;
            end
            PH_OPTION:
            begin
                if (rx_byte == OPT_TERMTYPE)
                begin
                    if (cur.option_verb == VERB_WILL)
                        res.out_kind = K_TTREQ;
                end
                else if (rx_byte == OPT_EOR)
                begin
                    if (cur.option_verb == VERB_WILL)
                        nxt.will_record_end_seen = 1'b1;
                    else if (cur.option_verb == VERB_DO)
                        nxt.do_record_end_seen = 1'b1;
                end
                else if (rx_byte == OPT_BINARY)
                begin
                    if (cur.option_verb == VERB_WILL)
                        nxt.will_binary_seen = 1'b1;
                    else if (cur.option_verb == VERB_DO)
                        nxt.do_binary_seen = 1'b1;
                end
            end
            default:
            begin
                // unused phase codes fall back to normal data
                if (rx_byte == CMD_IAC)
                begin
                    nxt.parse_phase = PH_IAC;
                end
                else
                begin
                    res.out_kind = data_kind;
                    res.out_byte = rx_byte;
                end
            end
        endcase

        res.negotiation_done = nxt.will_binary_seen & nxt.do_binary_seen &
                               nxt.will_record_end_seen & nxt.do_record_end_seen &
                               nxt.terminal_type_seen;
    end

endmodule

// ----- rtl/telnet_option_stream_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_option_stream_parser
// Telnet command parser for a TN3270 client byte stream, one result per byte.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request lands in the input register, then moves to the
//   result register once that is free; a stalled result channel holds it there.
// Throughput: 1 byte per cycle while the result channel is not stalled.
// Reset: asynchronous, active low; clears the parse phase, verb and all
//   negotiation flags and empties both register stages.
module telnet_option_stream_parser
    import tosp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tosp_in_if.sink       rx,
    tosp_out_if.source    res
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    tosp_state_t  state_reg;
    tosp_state_t  state_next;
    logic         out_valid_reg;
    tosp_result_t out_res_reg;
    tosp_result_t out_res_next;
    logic         out_load;
    logic         in_load;

    tosp_decode u_decode (
        .cur     (state_reg),
        .rx_byte (in_byte_reg),
        .nxt     (state_next),
        .res     (out_res_next)
    );

    // advance the held request once the result register is free
    assign out_load = in_valid_reg & (~out_valid_reg | res.ready);
    assign in_load  = ~in_valid_reg | out_load;
    assign rx.ready = in_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_load)
                in_valid_reg <= rx.valid;
            if (out_load)
                state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && rx.valid)
            in_byte_reg <= rx.rx_byte;
        if (out_load)
            out_res_reg <= out_res_next;
    end

    assign res.valid            = out_valid_reg;
    assign res.out_kind         = out_res_reg.out_kind;
    assign res.out_byte         = out_res_reg.out_byte;
    assign res.negotiation_done = out_res_reg.negotiation_done;

    // Assertions
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.parse_phase <= PH_SUBOP)
        else $error("parse phase left the legal range");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.will_binary_seen && state_reg.do_binary_seen &&
         state_reg.will_record_end_seen && state_reg.do_record_end_seen &&
         state_reg.terminal_type_seen)
        |=> (state_reg.will_binary_seen && state_reg.do_binary_seen &&
             state_reg.will_record_end_seen && state_reg.do_record_end_seen &&
             state_reg.terminal_type_seen))
        else $error("negotiation flags cleared after completion");

    a_fwd_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.out_kind == K_FWD) |-> res.negotiation_done)
        else $error("data forwarded before negotiation finished");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.out_kind != K_FWD && res.out_kind != K_DROP &&
         res.out_kind != K_TTBYTE) |-> (res.out_byte == 8'd0))
        else $error("byte carried with a kind that has none");

endmodule
